// File: src/mmpvl_pkg.sv
// shared types and constants of the multi-motor pi velocity loop
package mmpvl_pkg;

  localparam int IDX_W    = 4;
  localparam int SLOT_CODES = 2 ** IDX_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  localparam logic [15:0] PROP_GAIN_RST   = 16'd640;
  localparam logic [15:0] INTEG_GAIN_RST  = 16'd1280;
  localparam logic [30:0] INTEG_LIMIT_RST = 31'd655360;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    REQ_SET_TARGET,
    REQ_DISARM,
    REQ_STEP,
    REQ_CLEAR
  } req_code_t;

  typedef enum logic [1:0] {
    ACT_TORQUE,
    ACT_VELOCITY,
    ACT_POSITION
  } act_code_t;

  typedef enum logic [1:0] {
    CFG_PROP_GAIN,
    CFG_INTEG_GAIN,
    CFG_INTEG_LIMIT
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL_P,
    ST_MUL_I1,
    ST_MUL_I2,
    ST_INTEG,
    ST_TORQUE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    req_code_t          req_type;
    logic [IDX_W-1:0]   motor_index;
    logic signed [31:0] target_rate;
    logic signed [31:0] measured_velocity;
    logic [15:0]        time_step;
    logic [1:0]         actuator_kind;
    logic signed [31:0] range_min;
    logic signed [31:0] range_max;
    logic               reversed;
  } req_item_t;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
    logic signed [40:0] hi;
    logic signed [40:0] lo;
    hi = 41'(S32_MAX);
    lo = 41'(S32_MIN);
    if (v > hi) return S32_MAX;
    if (v < lo) return S32_MIN;
    return v[31:0];
  endfunction

  // drop sh fraction bits, round half away from zero
  function automatic logic signed [64:0] round_drop(input logic signed [64:0] v,
                                                    input int unsigned sh);
    logic signed [64:0] half;
    logic signed [64:0] adj;
    half = 65'sd1 <<< (sh - 1);
    adj  = $signed({64'd0, v[64]});
    return (v + half - adj) >>> sh;
  endfunction

endpackage

// File: src/mmpvl_if.sv
// request and response channel interfaces of the multi-motor pi velocity loop
interface mmpvl_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [3:0]         motor_index;
  logic signed [31:0] target_rate;
  logic signed [31:0] measured_velocity;
  logic [15:0]        time_step;
  logic [1:0]         actuator_kind;
  logic signed [31:0] range_min;
  logic signed [31:0] range_max;
  logic               reversed;

  modport source (
    output valid, req_type, motor_index, target_rate, measured_velocity,
           time_step, actuator_kind, range_min, range_max, reversed,
    input  ready
  );
  modport sink (
    input  valid, req_type, motor_index, target_rate, measured_velocity,
           time_step, actuator_kind, range_min, range_max, reversed,
    output ready
  );
endinterface

interface mmpvl_rsp_if;
  logic               valid;
  logic               ready;
  logic [3:0]         out_motor;
  logic signed [31:0] command;
  logic [30:0]        peak_error;

  modport source (
    output valid, out_motor, command, peak_error,
    input  ready
  );
  modport sink (
    input  valid, out_motor, command, peak_error,
    output ready
  );
endinterface

// File: src/multi_motor_pi_velocity_loop.sv
// per-slot pi velocity loop with conditional-integration anti-windup
//
// requests come in on req, one at a time; req.ready is high only while the
// sequencer is idle. set-target, disarm and clear requests give no response.
// a step on an armed slot with a nonzero time step gives one response on rsp:
// a velocity actuator step goes straight to the finish state, a torque or
// position step runs all three products (p term, gain*error, times time step)
// one after another through a single 48x17 multiplier.
// other steps end with no response.
// the response sits in an output register; while it waits the next request
// is taken, and a later step holds in its last state until rsp is free.
// config writes go through cfg_we/cfg_index/cfg_data and must only come
// while the block is idle; index 3 is ignored.
// reset (synchronous, active high) disarms all slots, zeroes integrals and
// the peak, and loads the default gains and integral limit. integrals use
// per-slot valid bits, so reset and the clear request clear those bits only.
module multi_motor_pi_velocity_loop #(
  parameter int MOTOR_SLOTS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [mmpvl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mmpvl_pkg::CFG_DATA_W-1:0]  cfg_data,
  mmpvl_req_if.sink                         req,
  mmpvl_rsp_if.source                       rsp
);
  import mmpvl_pkg::*;

  localparam int DEPTH = (MOTOR_SLOTS < SLOT_CODES) ? MOTOR_SLOTS : SLOT_CODES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  state_t state;
  state_t state_next;

  logic [15:0] prop_gain;
  logic [15:0] integ_gain;
  logic [30:0] integ_limit;

  req_item_t          item;
  logic [AW-1:0]      cur_addr;
  logic               cur_in_range;
  logic [DEPTH-1:0]   armed;
  logic [DEPTH-1:0]   integ_vld;
  logic signed [31:0] tgt_mem [DEPTH];
  logic signed [31:0] int_mem [DEPTH];
  logic signed [31:0] rd_target;
  logic signed [31:0] rd_integ;
  logic               rd_ivld;

  logic signed [31:0] err;
  logic signed [64:0] prod;
  logic signed [39:0] p_rnd;
  logic signed [31:0] integ_new;
  logic signed [31:0] cmd_pre;
  logic [30:0]        peak;

  logic               out_valid;
  logic [IDX_W-1:0]   out_motor_q;
  logic signed [31:0] command_q;
  logic [30:0]        peak_q;

  logic               in_range;
  logic [AW-1:0]      in_addr;
  logic               step_ok;
  logic               bounded;
  logic               out_free;

  logic signed [32:0] diff;
  logic signed [31:0] err_sat;
  logic [31:0]        mag32;
  logic [30:0]        err_mag;
  logic signed [47:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [31:0] integ_old;
  logic signed [40:0] inc;
  logic signed [40:0] isum;
  logic signed [40:0] lim;
  logic signed [40:0] isum_lim;
  logic signed [40:0] torque;
  logic signed [40:0] torque_clamped;
  logic signed [31:0] vel_cmd;

  assign in_range = 32'(req.motor_index) < 32'(MOTOR_SLOTS);
  assign in_addr  = in_range ? req.motor_index[AW-1:0] : '0;
  assign step_ok  = cur_in_range && armed[cur_addr] && (item.time_step != '0);
  assign bounded  = item.range_min < item.range_max;
  assign out_free = !out_valid || rsp.ready;

  assign req.ready      = (state == ST_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.out_motor  = out_motor_q;
  assign rsp.command    = command_q;
  assign rsp.peak_error = peak_q;

  // error and its saturated magnitude
  always_comb begin
    diff    = 33'(rd_target) - 33'(item.measured_velocity);
    err_sat = sat32(41'(diff));
    mag32   = err_sat[31] ? 32'(-33'(err_sat)) : 32'(err_sat);
    err_mag = mag32[31] ? 31'h7FFF_FFFF : mag32[30:0];
  end

  // operand selection of the shared multiplier
  always_comb begin
    mul_a = 48'(err);
    mul_b = {1'b0, prop_gain};
    case (state)
      ST_MUL_I1: mul_b = {1'b0, integ_gain};
      ST_MUL_I2: begin
        mul_a = prod[47:0];
        mul_b = {1'b0, item.time_step};
      end
      default: ;
    endcase
  end

  // integral update with limit clamp
  always_comb begin
    integ_old = rd_ivld ? rd_integ : 32'sd0;
    inc       = 41'(round_drop(prod, 24));
    isum      = 41'(integ_old) + inc;
    lim       = 41'($signed({1'b0, integ_limit}));
    isum_lim  = isum;
    if (integ_limit != '0) begin
      if (isum > lim) isum_lim = lim;
      else if (isum < -lim) isum_lim = -lim;
    end
  end

  // torque and range clamp
  always_comb begin
    torque         = 41'(p_rnd) + 41'(integ_new);
    torque_clamped = torque;
    if (bounded) begin
      if (torque < 41'(item.range_min)) torque_clamped = 41'(item.range_min);
      else if (torque > 41'(item.range_max)) torque_clamped = 41'(item.range_max);
    end
    vel_cmd = rd_target;
    if (bounded) begin
      if (rd_target < item.range_min) vel_cmd = item.range_min;
      else if (rd_target > item.range_max) vel_cmd = item.range_max;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (req.valid) state_next = ST_EXEC;
      ST_EXEC: begin
        if (item.req_type == REQ_STEP && step_ok) begin
          state_next = (item.actuator_kind == ACT_VELOCITY) ? ST_FINISH : ST_MUL_P;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_MUL_P:  state_next = ST_MUL_I1;
      ST_MUL_I1: state_next = ST_MUL_I2;
      ST_MUL_I2: state_next = ST_INTEG;
      ST_INTEG:  state_next = ST_TORQUE;
      ST_TORQUE: state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain   <= PROP_GAIN_RST;
      integ_gain  <= INTEG_GAIN_RST;
      integ_limit <= INTEG_LIMIT_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_PROP_GAIN) prop_gain <= cfg_data[15:0];
      else if (cfg_index == CFG_INTEG_GAIN) integ_gain <= cfg_data[15:0];
      else if (cfg_index == CFG_INTEG_LIMIT) integ_limit <= cfg_data;
    end
  end

  // request capture and slot state reads
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req.valid) begin
      item.req_type          <= req_code_t'(req.req_type);
      item.motor_index       <= req.motor_index;
      item.target_rate       <= req.target_rate;
      item.measured_velocity <= req.measured_velocity;
      item.time_step         <= req.time_step;
      item.actuator_kind     <= req.actuator_kind;
      item.range_min         <= req.range_min;
      item.range_max         <= req.range_max;
      item.reversed          <= req.reversed;
      cur_addr               <= in_addr;
      cur_in_range           <= in_range;
      rd_target              <= tgt_mem[in_addr];
      rd_integ               <= int_mem[in_addr];
      rd_ivld                <= integ_vld[in_addr];
    end
  end

  // target and integral memories
  always_ff @(posedge clk) begin
    if (state == ST_EXEC && item.req_type == REQ_SET_TARGET && cur_in_range &&
        item.actuator_kind != ACT_POSITION) begin
      tgt_mem[cur_addr] <= item.target_rate;
    end
    if (state == ST_TORQUE) begin
      // hold the integral whenever the range clamp acts
      int_mem[cur_addr] <= (torque_clamped != torque) ? integ_old : integ_new;
    end
  end

  // armed flags, integral valid bits and peak
  always_ff @(posedge clk) begin
    if (rst) begin
      armed     <= '0;
      integ_vld <= '0;
      peak      <= '0;
    end else begin
      if (state == ST_EXEC) begin
        case (item.req_type)
          REQ_CLEAR: begin
            integ_vld <= '0;
            peak      <= '0;
          end
          REQ_SET_TARGET: begin
            if (cur_in_range && item.actuator_kind != ACT_POSITION) begin
              // arming a free slot starts from a zero integral
              if (!armed[cur_addr]) integ_vld[cur_addr] <= 1'b0;
              armed[cur_addr] <= 1'b1;
            end
          end
          REQ_DISARM: if (cur_in_range) armed[cur_addr] <= 1'b0;
          REQ_STEP: begin
            if (step_ok && item.actuator_kind != ACT_VELOCITY && err_mag > peak) begin
              peak <= err_mag;
            end
          end
          default: ;
        endcase
      end
      if (state == ST_TORQUE) integ_vld[cur_addr] <= 1'b1;
    end
  end

  // arithmetic datapath
  always_ff @(posedge clk) begin
    prod <= 65'(mul_a) * 65'(mul_b);
    if (state == ST_EXEC) begin
      err     <= err_sat;
      cmd_pre <= vel_cmd;
    end
    if (state == ST_MUL_I1) p_rnd <= 40'(round_drop(prod, 8));
    if (state == ST_INTEG)  integ_new <= sat32(isum_lim);
    if (state == ST_TORQUE) cmd_pre <= sat32(torque_clamped);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      out_motor_q <= item.motor_index;
      peak_q      <= peak;
      if (item.reversed) command_q <= (cmd_pre == S32_MIN) ? S32_MAX : -cmd_pre;
      else               command_q <= cmd_pre;
    end
  end

  a_rsp_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FINISH)
    else $error("response raised outside the finish state");

  a_peak_falls_on_clear: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && peak < $past(peak)) |->
      ($past(state) == ST_EXEC && $past(item.req_type) == REQ_CLEAR))
    else $error("peak error dropped without a clear request");

  a_finish_loads_slot: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && out_free) |=> (out_valid && out_motor_q == $past(item.motor_index)))
    else $error("finished step did not load its slot into the response");

endmodule
